@@ src/npcs_pkg.sv @@
// Package for the nearest palette color search unit: sizes, field widths,
// codes, the packed color entry, pipeline tag and controller state type.
// No dependencies.
package npcs_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W         = $clog2(PALETTE_DEPTH);
    localparam int COUNT_W       = 9;
    localparam int CHAN_W        = 16;
    localparam int SQ_W          = 2 * CHAN_W;
    localparam int DIST_W        = 34;
    localparam int ENTRY_IDX_W   = 8;
    localparam int OUT_IDX_W     = 8;
    localparam int PDATA_W       = 32;
    localparam int PADDR_W       = 2;

    localparam logic [COUNT_W-1:0] COLOR_COUNT_RESET = COUNT_W'(256);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } npcs_color_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } npcs_tag_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } npcs_state_t;

endpackage

@@ src/npcs_ifs.sv @@
// Handshake channel interfaces of the nearest palette color search unit:
// the request channel (palette writes and queries) and the result channel.
// Depends on npcs_pkg.
interface npcs_req_if
    import npcs_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [CHAN_W-1:0]      red_value;
    logic [CHAN_W-1:0]      green_value;
    logic [CHAN_W-1:0]      blue_value;

    modport source (
        output valid, mode, entry_index, red_value, green_value, blue_value,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_index, red_value, green_value, blue_value,
        output ready
    );
endinterface

interface npcs_rsp_if
    import npcs_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] best_index;
    logic [DIST_W-1:0]    best_distance;

    modport source (
        output valid, best_index, best_distance,
        input  ready
    );
    modport sink (
        input  valid, best_index, best_distance,
        output ready
    );
endinterface

@@ src/npcs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered. No dependencies.
module npcs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/npcs_dist.sv @@
// Three-stage squared distance pipeline: channel differences, squares,
// then the exact 34-bit sum. Carries the entry index tag alongside.
// Depends on npcs_pkg.
module npcs_dist
    import npcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  npcs_tag_t         tag_in,
    input  npcs_color_t       query,
    input  npcs_color_t       entry,
    output npcs_tag_t         tag_out,
    output logic [DIST_W-1:0] sq_dist,
    output logic              busy
);

    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [IDX_W-1:0]  s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic [CHAN_W-1:0] dr_reg, dg_reg, db_reg;
    logic [SQ_W-1:0]   sr_reg, sg_reg, sb_reg;
    logic [DIST_W-1:0] sum_reg;

    logic [CHAN_W-1:0] dr_next, dg_next, db_next;

    always_comb
    begin
        dr_next = (query.red >= entry.red) ? query.red - entry.red
                                           : entry.red - query.red;
        dg_next = (query.green >= entry.green) ? query.green - entry.green
                                               : entry.green - query.green;
        db_next = (query.blue >= entry.blue) ? query.blue - entry.blue
                                             : entry.blue - query.blue;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= tag_in.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= tag_in.idx;
        s2_idx_reg <= s1_idx_reg;
        s3_idx_reg <= s2_idx_reg;
        dr_reg  <= dr_next;
        dg_reg  <= dg_next;
        db_reg  <= db_next;
        sr_reg  <= SQ_W'(dr_reg) * SQ_W'(dr_reg);
        sg_reg  <= SQ_W'(dg_reg) * SQ_W'(dg_reg);
        sb_reg  <= SQ_W'(db_reg) * SQ_W'(db_reg);
        sum_reg <= DIST_W'(sr_reg) + DIST_W'(sg_reg) + DIST_W'(sb_reg);
    end

    assign tag_out = '{valid: s3_valid_reg, idx: s3_idx_reg};
    assign sq_dist = sum_reg;
    assign busy    = s1_valid_reg | s2_valid_reg | s3_valid_reg;

endmodule

@@ src/nearest_palette_color_search_unit.sv @@
// Nearest palette color search unit. A write beat (mode 0) stores one
// 16-bit-per-channel RGB entry in the palette memory and gives no result.
// A query beat (mode 1) reads entries 0 to color_count-1, one per cycle
// through the memory's single read port, and returns the index of the
// entry with the least exact squared RGB distance (lowest index on ties)
// with that distance. Each entry passes the registered read port and a
// four-stage distance/compare pipeline; once that is empty and the output
// register is free, the result is loaded into it, and new requests are
// taken from the cycle the result beat is presented. One request is
// processed at a time; a finished result waits in an output register
// while the next request is taken. The palette is not cleared at reset:
// write every entry in use before querying. color_count of 0 acts as 1;
// counts above the palette depth search the whole palette.
// Depends on npcs_pkg, npcs_ifs, npcs_ram and npcs_dist.
module nearest_palette_color_search_unit
    import npcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    npcs_req_if.sink           req,
    npcs_rsp_if.source         rsp
);

    localparam int CMP_W = (COUNT_W > IDX_W + 1) ? COUNT_W : IDX_W + 1;
    localparam int ENT_W = (ENTRY_IDX_W > IDX_W + 1) ? ENTRY_IDX_W : IDX_W + 1;

    npcs_state_t state_reg, state_next;

    logic [COUNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]     addr_reg, addr_next;
    logic [IDX_W-1:0]     last_reg, last_next;
    npcs_color_t          query_reg;
    logic                 rd_valid_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    npcs_tag_t            rd_tag, rd_tag_next;
    logic [DIST_W-1:0]    best_d_reg;
    logic [IDX_W-1:0]     best_i_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_IDX_W-1:0] out_idx_reg;
    logic [DIST_W-1:0]    out_dist_reg;

    logic        req_fire, wr_fire, query_fire;
    logic        scan_issue, finish, slot_free, pipe_empty;
    logic [CMP_W-1:0] cnt_ext;
    npcs_color_t wr_color, entry;
    npcs_tag_t   sum_tag;
    logic [DIST_W-1:0] sum_dist;
    logic        dist_busy;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = PDATA_W'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COLOR_COUNT_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == '0))
        begin
            count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // ---------------- request decode ----------------
    assign req_fire   = req.valid && req.ready;
    assign wr_fire    = req_fire && (req.mode == MODE_WRITE)
                        && (ENT_W'(req.entry_index) < ENT_W'(PALETTE_DEPTH));
    assign query_fire = req_fire && (req.mode == MODE_QUERY);

    assign wr_color.red   = req.red_value;
    assign wr_color.green = req.green_value;
    assign wr_color.blue  = req.blue_value;

    // Clamp the count to 1..PALETTE_DEPTH and keep the last index scanned.
    always_comb
    begin
        cnt_ext = CMP_W'(count_reg);
        if (cnt_ext == '0)
        begin
            last_next = '0;
        end
        else if (cnt_ext > CMP_W'(PALETTE_DEPTH))
        begin
            last_next = IDX_W'(PALETTE_DEPTH - 1);
        end
        else
        begin
            last_next = IDX_W'(cnt_ext - CMP_W'(1));
        end
    end

    // ---------------- controller ----------------
    assign pipe_empty = !rd_valid_reg && !dist_busy;
    assign slot_free  = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_fire)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (addr_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pipe_empty && slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready  = 1'b0;
        scan_issue = 1'b0;
        finish     = 1'b0;
        unique case (state_reg)
            ST_IDLE:  req.ready  = 1'b1;
            ST_SCAN:  scan_issue = 1'b1;
            ST_DRAIN: finish     = pipe_empty && slot_free;
            default:  req.ready  = 1'b0;
        endcase
    end

    always_comb
    begin
        addr_next = addr_reg;
        if (query_fire)
        begin
            addr_next = '0;
        end
        else if (scan_issue)
        begin
            addr_next = addr_reg + IDX_W'(1);
        end
        rd_tag_next.valid = scan_issue;
        rd_tag_next.idx   = addr_reg;
    end

    assign rd_tag = '{valid: rd_valid_reg, idx: rd_idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_tag_next.valid;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        rd_idx_reg <= rd_tag_next.idx;
        if (query_fire)
        begin
            last_reg  <= last_next;
            query_reg <= wr_color;
        end
        // Entry zero always seeds the running minimum.
        if (sum_tag.valid && ((sum_tag.idx == '0) || (sum_dist < best_d_reg)))
        begin
            best_d_reg <= sum_dist;
            best_i_reg <= sum_tag.idx;
        end
        if (finish)
        begin
            out_idx_reg  <= OUT_IDX_W'(best_i_reg);
            out_dist_reg <= best_d_reg;
        end
    end

    // ---------------- palette memory and distance pipeline ----------------
    npcs_ram #(
        .WIDTH ($bits(npcs_color_t)),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (wr_fire),
        .waddr (IDX_W'(req.entry_index)),
        .wdata (wr_color),
        .raddr (addr_reg),
        .rdata (entry)
    );

    npcs_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (rd_tag),
        .query   (query_reg),
        .entry   (entry),
        .tag_out (sum_tag),
        .sq_dist (sum_dist),
        .busy    (dist_busy)
    );

    assign rsp.valid         = out_valid_reg;
    assign rsp.best_index    = out_idx_reg;
    assign rsp.best_distance = out_dist_reg;

endmodule

@@ tb/npcs_search_check.sv @@
// Result checker for the nearest palette color search unit: mirrors the
// palette and color_count from observed beats and APB writes, predicts each
// query's nearest entry and compares it with the result beats.
// Depends on npcs_pkg and npcs_ifs.
module npcs_search_check
    import npcs_pkg::*;
#(
    parameter logic [PADDR_W-1:0] COUNT_ADDR = '0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    npcs_req_if                req,
    npcs_rsp_if                rsp,
    output int                 error_count,
    output int                 pending_count,
    output int                 result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] index;
        logic [DIST_W-1:0]    distance;
    } nearest_t;

    npcs_color_t        palette_mirror [PALETTE_DEPTH];
    logic [COUNT_W-1:0] search_count = COLOR_COUNT_RESET;
    nearest_t           nearest_q [$];

    initial
    begin
        error_count   = 0;
        pending_count = 0;
        result_count  = 0;
    end

    function automatic logic [SQ_W-1:0] chan_square(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] diff;
        diff = (a >= b) ? a - b : b - a;
        return SQ_W'(diff) * SQ_W'(diff);
    endfunction

    function automatic nearest_t search_nearest(npcs_color_t color);
        int                span;
        logic [DIST_W-1:0] entry_dist;
        nearest_t          best;
        span = (search_count == '0) ? 1 : int'(search_count);
        if (span > PALETTE_DEPTH)
            span = PALETTE_DEPTH;
        best = '0;
        for (int i = 0; i < span; i++)
        begin
            entry_dist = DIST_W'(chan_square(color.red, palette_mirror[i].red))
                       + DIST_W'(chan_square(color.green, palette_mirror[i].green))
                       + DIST_W'(chan_square(color.blue, palette_mirror[i].blue));
            // strict less-than keeps the lowest index on a tie
            if (i == 0 || entry_dist < best.distance)
            begin
                best.distance = entry_dist;
                best.index    = OUT_IDX_W'(i);
            end
        end
        return best;
    endfunction

    always @(posedge clk)
    begin
        nearest_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                if (req.mode == MODE_WRITE)
                begin
                    if (int'(req.entry_index) < PALETTE_DEPTH)
                        palette_mirror[req.entry_index] = '{req.red_value, req.green_value,
                                                            req.blue_value};
                end
                else
                    nearest_q.push_back(search_nearest('{req.red_value, req.green_value,
                                                         req.blue_value}));
            end

            if (rsp.valid && rsp.ready)
            begin
                result_count++;
                if (nearest_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result beat with nothing expected: index %0d distance %0d",
                             $time, rsp.best_index, rsp.best_distance);
                end
                else
                begin
                    want = nearest_q.pop_front();
                    if (rsp.best_index !== want.index)
                    begin
                        error_count++;
                        $display("%0t: best_index expected %0d actual %0d",
                                 $time, want.index, rsp.best_index);
                    end
                    if (rsp.best_distance !== want.distance)
                    begin
                        error_count++;
                        $display("%0t: best_distance expected %0d actual %0d",
                                 $time, want.distance, rsp.best_distance);
                    end
                end
            end

            // register write lands after the beat taken at this same edge
            if (psel && penable && pwrite && pready && paddr == COUNT_ADDR)
                search_count = pwdata[COUNT_W-1:0];

            pending_count = nearest_q.size();
        end
    end

endmodule

@@ tb/nearest_palette_color_search_unit_tb.sv @@
// Testbench top for the nearest palette color search unit: fills the palette,
// runs directed and random queries over many color_count settings with
// random stalls on both channels. Depends on all of src and npcs_search_check.
module nearest_palette_color_search_unit_tb;
    import npcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PADDR_W-1:0] COLOR_COUNT_ADDR = PADDR_W'(0);
    localparam int QUIET_CYCLES      = 16;
    localparam int DRAIN_CYCLES      = PALETTE_DEPTH + 32;
    localparam int RUN_LIMIT_CYCLES  = 2_000_000;
    localparam int RANDOM_PHASES     = 10;
    localparam int BEATS_PER_PHASE   = 80;
    localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int error_count;
    int pending_count;
    int result_count;

    npcs_req_if req_ch ();
    npcs_rsp_if rsp_ch ();

    nearest_palette_color_search_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    npcs_search_check #(
        .COUNT_ADDR (COLOR_COUNT_ADDR)
    ) i_search_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .error_count   (error_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    npcs_color_t palette_shadow [PALETTE_DEPTH];
    int          active_span;
    int          write_count;
    int          query_count;
    int          setting_count;
    logic        no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (RUN_LIMIT_CYCLES) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CHAN_W-1:0] pick_chan();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return CHAN_MAX;
            2: return CHAN_W'($urandom_range(0, 15));
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    // span > 0 allows copying an entry in the searched range, which makes ties
    function automatic npcs_color_t pick_color(int span);
        if (span > 0 && $urandom_range(0, 3) == 0)
            return palette_shadow[$urandom_range(0, span - 1)];
        return '{pick_chan(), pick_chan(), pick_chan()};
    endfunction

    task automatic send_beat(logic mode, logic [ENTRY_IDX_W-1:0] index, npcs_color_t color);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= mode;
        req_ch.entry_index <= index;
        req_ch.red_value   <= color.red;
        req_ch.green_value <= color.green;
        req_ch.blue_value  <= color.blue;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        if (mode == MODE_WRITE)
        begin
            palette_shadow[index] = color;
            write_count++;
        end
        else
            query_count++;
    endtask

    task automatic send_query(npcs_color_t color);
        send_beat(MODE_QUERY, ENTRY_IDX_W'($urandom), color);
    endtask

    // drop valid and let every query finish before touching the register
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic set_color_count(logic [COUNT_W-1:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COLOR_COUNT_ADDR;
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (value == '0)
            active_span = 1;
        else if (int'(value) > PALETTE_DEPTH)
            active_span = PALETTE_DEPTH;
        else
            active_span = int'(value);
        setting_count++;
    endtask

    // result channel back-pressure
    initial
    begin
        int stall;
        int run;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
            repeat (run) @(negedge clk);
        end
    end

    initial
    begin
        logic [COUNT_W-1:0] count_value;
        logic [ENTRY_IDX_W-1:0] index;
        npcs_color_t color;

        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_ch.valid       = 1'b0;
        req_ch.mode        = MODE_WRITE;
        req_ch.entry_index = '0;
        req_ch.red_value   = '0;
        req_ch.green_value = '0;
        req_ch.blue_value  = '0;
        no_gaps            = 1'b0;
        active_span        = PALETTE_DEPTH;
        write_count        = 0;
        query_count        = 0;
        setting_count      = 0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // fill the whole palette: zero at 0 and 2, full scale at 1
        for (int i = 0; i < PALETTE_DEPTH; i++)
        begin
            if (i == 0 || i == 2)
                color = '0;
            else if (i == 1)
                color = '1;
            else
                color = pick_color(0);
            send_beat(MODE_WRITE, ENTRY_IDX_W'(i), color);
        end

        // reset count searches the full palette; zero ties between 0 and 2
        send_query('0);
        send_query('1);
        send_query(palette_shadow[PALETTE_DEPTH - 1]);
        send_query(palette_shadow[PALETTE_DEPTH / 2]);

        // single entry of zero: full-scale query gives the largest distance
        set_color_count(COUNT_W'(1));
        send_query('1);
        send_query('{CHAN_MAX, 16'h0000, 16'h0000});

        set_color_count(COUNT_W'(0));
        send_query('{16'h0000, CHAN_MAX, 16'h0000});
        send_query('{CHAN_MAX, 16'h0000, CHAN_MAX});

        set_color_count(COUNT_W'(2));
        send_beat(MODE_WRITE, ENTRY_IDX_W'(1), '0);
        send_query('0);
        send_query('1);

        // counts beyond the depth saturate
        set_color_count('1);
        send_query(palette_shadow[PALETTE_DEPTH - 1]);
        send_query('0);
        set_color_count(COUNT_W'(PALETTE_DEPTH + 1));
        send_query(pick_color(0));
        send_query('1);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 5)
                0: count_value = COUNT_W'($urandom_range(1, 8));
                1: count_value = COUNT_W'($urandom_range(9, 64));
                2: count_value = COUNT_W'($urandom_range(0, 32));
                3: count_value = COUNT_W'($urandom_range(65, PALETTE_DEPTH));
                default: count_value = COUNT_W'($urandom);
            endcase
            set_color_count(count_value);
            no_gaps = (phase % 4 == 3);
            repeat (BEATS_PER_PHASE)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    // aim half the writes at the searched range
                    if ($urandom_range(0, 1) == 0)
                        index = ENTRY_IDX_W'($urandom_range(0, active_span - 1));
                    else
                        index = ENTRY_IDX_W'($urandom);
                    send_beat(MODE_WRITE, index, pick_color(active_span));
                end
                else
                    send_query(pick_color(active_span));
            end
        end

        req_ch.valid <= 1'b0;
        no_gaps = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d palette writes and %0d queries over %0d color_count settings,",
                 write_count, query_count, setting_count);
        $display("%0d result beats checked, %0d mismatches.", result_count, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
src/npcs_pkg.sv
src/npcs_ifs.sv
src/npcs_ram.sv
src/npcs_dist.sv
src/nearest_palette_color_search_unit.sv
tb/npcs_search_check.sv
tb/nearest_palette_color_search_unit_tb.sv
